@@ rtl/text_script_screen_writer_assert.svh @@
// assertion macros for the text script screen writer
// uses aclk and aresetn of the module that includes this header
`ifndef TEXT_SCRIPT_SCREEN_WRITER_ASSERT_SVH
`define TEXT_SCRIPT_SCREEN_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent on the same edge
`define TSW_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tsw: implication check failed");
// condition never holds
`define TSW_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("tsw: forbidden condition seen");
`else
`define TSW_ASSERT_IMPLY(label, ante, cons)
`define TSW_ASSERT_NEVER(label, cond)
`endif

`endif

@@ rtl/tsw_pkg.sv @@
// shared types and constants of the text script screen writer
// no dependencies; imported by the sequencer, the datapath and the top level
package tsw_pkg;

    // script store geometry
    localparam int SCRIPT_DEPTH = 256;
    localparam int ADDR_W       = $clog2(SCRIPT_DEPTH);
    localparam int PTR_W        = ADDR_W + 1;

    // screen geometry
    localparam int SCREEN_COLUMNS = 40;
    localparam int SCREEN_ROWS    = 25;
    localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ROW_W          = 5;
    localparam int INDEX_W        = 11;

    // burst length of a fast tick
    localparam int FAST_BURST = 40;
    localparam int CNT_W      = $clog2(FAST_BURST + 1);

    // script byte codes
    localparam logic [7:0] BYTE_END      = 8'hFF;
    localparam logic [7:0] BYTE_IDLE     = 8'h00;
    localparam logic [7:0] BYTE_NEWLINE  = 8'h0D;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_TONE_MIN = 8'h21;
    localparam logic [7:0] WRAP_COLUMN   = 8'h20;
    localparam logic [7:0] TONE_MASK_MIN = 8'd3;

    // configuration registers
    localparam logic       CFG_TEXT_COLOR   = 1'b0;
    localparam logic       CFG_GATE_MASK    = 1'b1;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'd1;
    localparam logic [7:0] GATE_MASK_RESET  = 8'd3;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_CURSOR = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_CURSOR  = 3'd1,
        ERR_NO_TERM = 3'd2,
        ERR_NEWLINE = 3'd3,
        ERR_WRITE   = 3'd4,
        ERR_WRAP    = 3'd5,
        ERR_LOAD    = 3'd6
    } err_t;

    // micro-operations driven by the sequencer into the datapath
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_TAKE,
        UOP_EXEC,
        UOP_INIT,
        UOP_READ,
        UOP_PROC,
        UOP_OVER
    } uop_t;

    // input beat
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] script_byte;
        logic [7:0] place_column;
        logic [7:0] place_row;
        logic [7:0] frame_num;
    } tsw_in_t;

    // result beat
    typedef struct packed {
        logic       write_enable;
        logic [9:0] screen_index;
        logic [5:0] glyph_code;
        logic [7:0] glyph_color;
        logic       tone;
        logic [7:0] consumed_byte;
        logic       byte_valid;
        logic       script_active;
        logic [7:0] cursor_column_now;
        logic [4:0] cursor_row_now;
        err_t       error;
        logic       last;
    } tsw_out_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic slot_free;
        logic tick_go;
        logic rp_over;
        logic last_now;
    } tsw_status_t;

endpackage

@@ rtl/tsw_sequencer.sv @@
// microprogram sequencer: step counter, control rom and branch logic
// depends on tsw_pkg
module tsw_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  tsw_pkg::tsw_status_t status,
    output tsw_pkg::uop_t       uop,
    output logic                s_ready
);
    import tsw_pkg::*;

    localparam int STEP_W = 3;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_WAIT,
        BR_TICK,
        BR_OVER,
        BR_LAST
    } branch_t;

    typedef struct packed {
        uop_t              op;
        logic              emit;
        branch_t           branch;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // program step addresses
    localparam logic [STEP_W-1:0] STEP_FETCH    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SIMPLE   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_BURST    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_READ     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_PROC     = 3'd5;
    localparam logic [STEP_W-1:0] STEP_LOOP     = 3'd6;
    localparam logic [STEP_W-1:0] STEP_OVER     = 3'd7;

    // control rom
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        case (step)
            STEP_FETCH:    w = '{UOP_TAKE, 1'b0, BR_WAIT,   STEP_FETCH};
            STEP_DISPATCH: w = '{UOP_NOP,  1'b0, BR_TICK,   STEP_BURST};
            STEP_SIMPLE:   w = '{UOP_EXEC, 1'b1, BR_ALWAYS, STEP_FETCH};
            STEP_BURST:    w = '{UOP_INIT, 1'b0, BR_NEXT,   STEP_FETCH};
            STEP_READ:     w = '{UOP_READ, 1'b0, BR_OVER,   STEP_OVER};
            STEP_PROC:     w = '{UOP_PROC, 1'b1, BR_LAST,   STEP_FETCH};
            STEP_LOOP:     w = '{UOP_NOP,  1'b0, BR_ALWAYS, STEP_READ};
            STEP_OVER:     w = '{UOP_OVER, 1'b1, BR_ALWAYS, STEP_FETCH};
            default:       w = '{UOP_NOP,  1'b0, BR_ALWAYS, STEP_FETCH};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    ctrl_word_t        word;
    logic              stall;
    logic              taken;

    assign word    = ucode(pc_reg);
    // a step that emits a result waits for a free output slot
    assign stall   = word.emit && !status.slot_free;
    assign uop     = stall ? UOP_NOP : word.op;
    assign s_ready = (word.op == UOP_TAKE);

    // branch condition
    always_comb begin
        case (word.branch)
            BR_NEXT:   taken = 1'b0;
            BR_ALWAYS: taken = 1'b1;
            BR_WAIT:   taken = !s_valid;
            BR_TICK:   taken = status.tick_go;
            BR_OVER:   taken = status.rp_over;
            BR_LAST:   taken = status.last_now;
            default:   taken = 1'b1;
        endcase
        if (stall) begin
            pc_next = pc_reg;
        end else if (taken) begin
            pc_next = word.target;
        end else begin
            pc_next = pc_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ rtl/tsw_datapath.sv @@
// datapath: script store, pointers, cursor, config registers and result register
// depends on tsw_pkg; driven one micro-operation per cycle by tsw_sequencer
module tsw_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tsw_pkg::uop_t        uop,
    input  logic                 s_valid,
    input  tsw_pkg::tsw_in_t     s_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    output tsw_pkg::tsw_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tsw_pkg::tsw_out_t    m_data
);
    import tsw_pkg::*;

    logic [7:0]       store_mem [SCRIPT_DEPTH];
    logic [7:0]       rd_data_reg;

    tsw_in_t          in_reg,    in_next;
    logic [PTR_W-1:0] lp_reg,    lp_next;
    logic [PTR_W-1:0] rp_reg,    rp_next;
    logic             ts_reg,    ts_next;
    logic             run_reg,   run_next;
    logic [7:0]       col_reg,   col_next;
    logic [ROW_W-1:0] row_reg,   row_next;
    logic [7:0]       color_reg, color_next;
    logic [7:0]       mask_reg,  mask_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             m_valid_reg, m_valid_next;
    tsw_out_t         m_data_reg,  m_data_next;

    tsw_out_t         res;
    err_t             err;
    logic             emit;
    logic             mem_we;
    logic             mem_re;
    logic             cursor_bad;
    logic             rp_over;
    logic             last_row;
    logic [7:0]       v;
    logic [7:0]       col_inc;
    logic [INDEX_W-1:0] cell_idx;

    assign v          = rd_data_reg;
    assign rp_over    = (rp_reg >= PTR_W'(SCRIPT_DEPTH));
    assign last_row   = (row_reg >= ROW_W'(SCREEN_ROWS - 1));
    assign cursor_bad = (in_reg.place_column >= 8'(SCREEN_COLUMNS))
                     || (in_reg.place_row >= 8'(SCREEN_ROWS));
    assign cell_idx   = INDEX_W'(row_reg) * INDEX_W'(SCREEN_COLUMNS) + INDEX_W'(col_reg);
    assign col_inc    = col_reg + 8'd1;

    assign status.slot_free = !m_valid_reg || m_ready;
    assign status.tick_go   = (in_reg.func == FUNC_TICK) && run_reg
                           && ((in_reg.frame_num & mask_reg) == 8'd0);
    assign status.rp_over   = rp_over;
    assign status.last_now  = res.last;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // micro-operation decode
    always_comb begin
        in_next    = in_reg;
        lp_next    = lp_reg;
        rp_next    = rp_reg;
        ts_next    = ts_reg;
        run_next   = run_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        color_next = color_reg;
        mask_next  = mask_reg;
        res        = '0;
        err        = ERR_NONE;
        emit       = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;

        // config writes land whenever offered
        if (cfg_valid) begin
            if (cfg_index == CFG_TEXT_COLOR) begin
                color_next = cfg_data;
            end else begin
                mask_next = cfg_data;
            end
        end

        case (uop)
            UOP_TAKE: begin
                if (s_valid) begin
                    in_next = s_data;
                end
            end
            // load, start, set cursor, idle tick: one result each
            UOP_EXEC: begin
                emit = 1'b1;
                case (in_reg.func)
                    FUNC_LOAD: begin
                        if (run_reg || lp_reg >= PTR_W'(SCRIPT_DEPTH)) begin
                            err = ERR_LOAD;
                        end else begin
                            mem_we  = 1'b1;
                            lp_next = lp_reg + PTR_W'(1);
                            if (in_reg.script_byte == BYTE_END) begin
                                ts_next = 1'b1;
                            end
                        end
                    end
                    FUNC_START: begin
                        if (cursor_bad) begin
                            err = ERR_CURSOR;
                        end else if (!ts_reg) begin
                            err = ERR_NO_TERM;
                        end else begin
                            rp_next  = '0;
                            lp_next  = '0;
                            ts_next  = 1'b0;
                            col_next = in_reg.place_column;
                            row_next = in_reg.place_row[ROW_W-1:0];
                            run_next = 1'b1;
                        end
                    end
                    FUNC_CURSOR: begin
                        if (cursor_bad) begin
                            err = ERR_CURSOR;
                        end else begin
                            col_next = in_reg.place_column;
                            row_next = in_reg.place_row[ROW_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
                if (err != ERR_NONE) begin
                    run_next = 1'b0;
                end
                res.last = 1'b1;
            end
            UOP_INIT: begin
                cnt_next = (mask_reg == 8'd0) ? CNT_W'(FAST_BURST) : CNT_W'(1);
            end
            UOP_READ: begin
                if (!rp_over) begin
                    mem_re  = 1'b1;
                    rp_next = rp_reg + PTR_W'(1);
                end
            end
            // interpret one script byte
            UOP_PROC: begin
                emit              = 1'b1;
                cnt_next          = cnt_reg - CNT_W'(1);
                res.consumed_byte = v;
                res.byte_valid    = (v != BYTE_END);
                res.tone          = (mask_reg >= TONE_MASK_MIN) && (v >= BYTE_TONE_MIN)
                                 && (v != BYTE_END);
                if (v == BYTE_END) begin
                    run_next = 1'b0;
                end else if (v == BYTE_IDLE) begin
                    col_next = col_reg;
                end else if (v[7]) begin
                    col_next = {2'b00, v[5:0]};
                end else if (v == BYTE_NEWLINE) begin
                    if (last_row) begin
                        err      = ERR_NEWLINE;
                        run_next = 1'b0;
                    end else begin
                        col_next = 8'd1;
                        row_next = row_reg + ROW_W'(1);
                    end
                end else if (cell_idx >= INDEX_W'(SCREEN_CELLS)) begin
                    err      = ERR_WRITE;
                    run_next = 1'b0;
                end else begin
                    res.write_enable = 1'b1;
                    res.screen_index = cell_idx[9:0];
                    res.glyph_code   = (v == BYTE_SPACE) ? 6'd0 : v[5:0];
                    res.glyph_color  = color_reg;
                    col_next         = col_inc;
                    // slow colour-zero text wraps after a space
                    if (v == BYTE_SPACE && mask_reg != 8'd0 && color_reg == 8'd0
                        && col_inc >= WRAP_COLUMN) begin
                        if (last_row) begin
                            err      = ERR_WRAP;
                            run_next = 1'b0;
                        end else begin
                            col_next = 8'd1;
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                end
                res.last = (err != ERR_NONE) || (v == BYTE_END) || (cnt_reg == CNT_W'(1));
            end
            // read past the end of the store
            UOP_OVER: begin
                emit     = 1'b1;
                err      = ERR_NO_TERM;
                run_next = 1'b0;
                res.last = 1'b1;
            end
            default: begin
            end
        endcase

        res.error             = err;
        res.script_active     = run_next;
        res.cursor_column_now = col_next;
        res.cursor_row_now    = row_next;

        // result register
        m_data_next = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // script store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[lp_reg[ADDR_W-1:0]] <= in_reg.script_byte;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[rp_reg[ADDR_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_reg      <= '0;
            rp_reg      <= '0;
            ts_reg      <= 1'b0;
            run_reg     <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            color_reg   <= TEXT_COLOR_RESET;
            mask_reg    <= GATE_MASK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            lp_reg      <= lp_next;
            rp_reg      <= rp_next;
            ts_reg      <= ts_next;
            run_reg     <= run_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            color_reg   <= color_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/text_script_screen_writer.sv @@
// Text script screen writer: runs a byte-coded script onto a 40x25 text screen.
//
// Input channel s_valid/s_ready/s_data carries one command per beat: load a
// script byte, start the script at a cursor, frame tick, or set the cursor.
// Result channel m_valid/m_ready/m_data returns the results of each command;
// the final result of a command has last set. Configuration channel
// cfg_valid/cfg_ready/cfg_index/cfg_data writes text_color (index 0) and
// the frame gate mask (index 1); cfg_ready is always high.
// Load, start, set cursor and an idle tick pass the fetch, dispatch and
// execute steps and give one result. A tick that runs passes fetch, dispatch
// and burst setup, then the read / interpret / loop steps of the microprogram
// around the registered store read for each script byte (no loop step after
// the last), up to 40 bytes when the cadence mask is zero. A new command is
// taken only after the last result of the previous one is in the output
// register.
// A stalled receiver holds the result register and the microprogram waits on
// the step that emits the next result. Reset returns the step counter to the
// fetch step, empties the result register, clears pointers, cursor and run
// state, and sets text_color to 1 and the frame gate mask to 3; the script
// store contents are not cleared.
// depends on tsw_pkg, tsw_sequencer, tsw_datapath and the assertion header
`include "text_script_screen_writer_assert.svh"

module text_script_screen_writer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tsw_pkg::tsw_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tsw_pkg::tsw_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import tsw_pkg::*;

    uop_t        uop;
    tsw_status_t status;

    assign cfg_ready = 1'b1;

    // microprogram control
    tsw_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .uop     (uop),
        .s_ready (s_ready)
    );

    // datapath and result register
    tsw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .uop       (uop),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // an error result always ends the command and stops the script
    `TSW_ASSERT_IMPLY(a_err_is_last, m_valid && m_data.error != ERR_NONE, m_data.last)
    `TSW_ASSERT_IMPLY(a_err_stops, m_valid && m_data.error != ERR_NONE, !m_data.script_active)
    // no new command while a burst is still producing results
    `TSW_ASSERT_NEVER(a_no_take_mid_burst, s_ready && m_valid && !m_data.last)
    // screen writes stay on the screen
    `TSW_ASSERT_IMPLY(a_write_on_screen, m_valid && m_data.write_enable,
        m_data.screen_index < 10'(SCREEN_CELLS))

endmodule

@@ sim/tb.sv @@
// testbench for the text script screen writer: directed and random command streams
// checked beat by beat against a predictor of the screen writes, cursor and errors
// depends on tsw_pkg and text_script_screen_writer
`timescale 1ns / 100ps

module tb;
    import tsw_pkg::*;

    // slowest run: about 500 commands, each up to 40 results behind long stalls
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 84;
    localparam int unsigned IDLE_PCT     = 26;
    localparam int          IN_W         = $bits(tsw_in_t);

    typedef logic [7:0] script_q_t[$];

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    tsw_in_t    s_data;
    logic       m_valid;
    logic       m_ready = 1'b0;
    tsw_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    // predicted block state
    logic [7:0]  script_mem [SCRIPT_DEPTH];
    int unsigned load_ptr;
    int unsigned read_ptr;
    bit          term_loaded;
    bit          script_running;
    logic [7:0]  cur_col;
    logic [4:0]  cur_row;
    logic [7:0]  color_reg;
    logic [7:0]  mask_reg;

    tsw_out_t    screen_results_due[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          steady_flow = 1'b0;

    text_script_screen_writer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void reset_model();
        load_ptr       = 0;
        read_ptr       = 0;
        term_loaded    = 1'b0;
        script_running = 1'b0;
        cur_col        = '0;
        cur_row        = '0;
        color_reg      = TEXT_COLOR_RESET;
        mask_reg       = GATE_MASK_RESET;
    endfunction

    function automatic void add_result(logic we, int unsigned idx, logic [5:0] code,
                                       logic [7:0] colr, logic tone, logic [7:0] b,
                                       logic bv, err_t err);
        tsw_out_t r;
        r.write_enable      = we;
        r.screen_index      = idx[9:0];
        r.glyph_code        = code;
        r.glyph_color       = colr;
        r.tone              = tone;
        r.consumed_byte     = b;
        r.byte_valid        = bv;
        r.script_active     = script_running;
        r.cursor_column_now = cur_col;
        r.cursor_row_now    = cur_row;
        r.error             = err;
        r.last              = 1'b0;
        screen_results_due = {screen_results_due, r};
    endfunction

    function automatic void mark_last();
        tsw_out_t r;
        r = screen_results_due.pop_back();
        r.last = 1'b1;
        screen_results_due = {screen_results_due, r};
    endfunction

    // one script byte: ends the script, idles, moves the cursor or writes a cell
    function automatic err_t consume_script_byte();
        logic [7:0]  b;
        logic        tone;
        int unsigned idx;
        logic [5:0]  code;
        err_t        err;
        err = ERR_NONE;
        if (read_ptr >= SCRIPT_DEPTH) begin
            script_running = 1'b0;
            add_result(1'b0, 0, '0, '0, 1'b0, '0, 1'b0, ERR_NO_TERM);
            return ERR_NO_TERM;
        end
        b = script_mem[read_ptr];
        read_ptr++;
        tone = (mask_reg >= TONE_MASK_MIN) && (b >= BYTE_TONE_MIN) && (b != BYTE_END);
        if (b == BYTE_END) begin
            script_running = 1'b0;
            add_result(1'b0, 0, '0, '0, 1'b0, BYTE_END, 1'b0, ERR_NONE);
            return ERR_NONE;
        end
        if (b == BYTE_IDLE) begin
            add_result(1'b0, 0, '0, '0, tone, b, 1'b1, ERR_NONE);
            return ERR_NONE;
        end
        if (b[7]) begin
            cur_col = {2'b00, b[5:0]};
            add_result(1'b0, 0, '0, '0, tone, b, 1'b1, ERR_NONE);
            return ERR_NONE;
        end
        if (b == BYTE_NEWLINE) begin
            if (int'(cur_row) + 1 >= SCREEN_ROWS) begin
                script_running = 1'b0;
                add_result(1'b0, 0, '0, '0, tone, b, 1'b1, ERR_NEWLINE);
                return ERR_NEWLINE;
            end
            cur_col = 8'd1;
            cur_row = cur_row + 5'd1;
            add_result(1'b0, 0, '0, '0, tone, b, 1'b1, ERR_NONE);
            return ERR_NONE;
        end
        idx = int'(cur_row) * SCREEN_COLUMNS + int'(cur_col);
        if (idx >= SCREEN_CELLS) begin
            script_running = 1'b0;
            add_result(1'b0, 0, '0, '0, tone, b, 1'b1, ERR_WRITE);
            return ERR_WRITE;
        end
        // space maps to code zero, everything else keeps its low six bits
        code = (b == BYTE_SPACE) ? 6'd0 : b[5:0];
        cur_col = cur_col + 8'd1;
        // slow colour-zero text wraps after a space past the wrap column
        if (b == BYTE_SPACE && mask_reg != 8'd0 && color_reg == 8'd0 &&
            cur_col >= WRAP_COLUMN) begin
            if (int'(cur_row) + 1 >= SCREEN_ROWS) begin
                script_running = 1'b0;
                err = ERR_WRAP;
            end else begin
                cur_col = 8'd1;
                cur_row = cur_row + 5'd1;
            end
        end
        add_result(1'b1, idx, code, color_reg, tone, b, 1'b1, err);
        return err;
    endfunction

    function automatic void interpret_command(tsw_in_t cmd);
        func_t       f;
        err_t        err;
        int unsigned n;
        int unsigned count;
        f = func_t'(cmd.func);
        // a tick that passes the cadence gate runs one byte or a burst
        if (f == FUNC_TICK && script_running && (cmd.frame_num & mask_reg) == 8'd0) begin
            count = (mask_reg == 8'd0) ? FAST_BURST : 1;
            n = 0;
            while (n < count && script_running) begin
                err = consume_script_byte();
                n++;
                if (err != ERR_NONE)
                    break;
            end
            mark_last();
            return;
        end
        err = ERR_NONE;
        case (f)
            FUNC_LOAD: begin
                if (script_running || load_ptr >= SCRIPT_DEPTH) begin
                    err = ERR_LOAD;
                end else begin
                    script_mem[load_ptr] = cmd.script_byte;
                    load_ptr++;
                    if (cmd.script_byte == BYTE_END)
                        term_loaded = 1'b1;
                end
            end
            FUNC_START: begin
                if (cmd.place_column >= SCREEN_COLUMNS || cmd.place_row >= SCREEN_ROWS) begin
                    err = ERR_CURSOR;
                end else if (!term_loaded) begin
                    err = ERR_NO_TERM;
                end else begin
                    read_ptr       = 0;
                    load_ptr       = 0;
                    term_loaded    = 1'b0;
                    cur_col        = cmd.place_column;
                    cur_row        = cmd.place_row[4:0];
                    script_running = 1'b1;
                end
            end
            FUNC_CURSOR: begin
                if (cmd.place_column >= SCREEN_COLUMNS || cmd.place_row >= SCREEN_ROWS) begin
                    err = ERR_CURSOR;
                end else begin
                    cur_col = cmd.place_column;
                    cur_row = cmd.place_row[4:0];
                end
            end
            default: ;
        endcase
        if (err != ERR_NONE)
            script_running = 1'b0;
        add_result(1'b0, 0, '0, '0, 1'b0, '0, 1'b0, err);
        mark_last();
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic compare_result(input tsw_out_t got);
        tsw_out_t want;
        if (screen_results_due.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: %h", got));
            return;
        end
        want = screen_results_due.pop_front();
        check_field("write_enable", 16'(got.write_enable), 16'(want.write_enable));
        check_field("screen_index", 16'(got.screen_index), 16'(want.screen_index));
        check_field("glyph_code", 16'(got.glyph_code), 16'(want.glyph_code));
        check_field("glyph_color", 16'(got.glyph_color), 16'(want.glyph_color));
        check_field("tone", 16'(got.tone), 16'(want.tone));
        check_field("consumed_byte", 16'(got.consumed_byte), 16'(want.consumed_byte));
        check_field("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
        check_field("script_active", 16'(got.script_active), 16'(want.script_active));
        check_field("cursor_column_now", 16'(got.cursor_column_now),
                    16'(want.cursor_column_now));
        check_field("cursor_row_now", 16'(got.cursor_row_now), 16'(want.cursor_row_now));
        check_field("error", 16'(got.error), 16'(want.error));
        check_field("last", 16'(got.last), 16'(want.last));
    endtask

    // result monitor and random receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            compare_result(m_data);
        m_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic send_cmd(input tsw_in_t cmd);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        interpret_command(cmd);
        items_sent++;
    endtask

    task automatic issue(input func_t f, input logic [7:0] b, input logic [7:0] col,
                         input logic [7:0] row, input logic [7:0] frame);
        tsw_in_t cmd;
        cmd.func          = f;
        cmd.script_byte   = b;
        cmd.place_column  = col;
        cmd.place_row     = row;
        cmd.frame_num     = frame;
        send_cmd(cmd);
    endtask

    task automatic load_byte(input logic [7:0] b);
        issue(FUNC_LOAD, b, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic start_at(input logic [7:0] col, input logic [7:0] row);
        issue(FUNC_START, 8'($urandom), col, row, 8'($urandom));
    endtask

    task automatic place_cursor(input logic [7:0] col, input logic [7:0] row);
        issue(FUNC_CURSOR, 8'($urandom), col, row, 8'($urandom));
    endtask

    task automatic tick(input logic [7:0] frame);
        issue(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom), frame);
    endtask

    task automatic load_script(input script_q_t script);
        foreach (script[i])
            load_byte(script[i]);
    endtask

    // a frame number that passes the cadence gate
    function automatic logic [7:0] passing_frame();
        return 8'($urandom) & ~mask_reg;
    endfunction

    task automatic play_script();
        while (script_running)
            tick(passing_frame());
    endtask

    // sender holds off until every expected beat has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (screen_results_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        if (idx == CFG_TEXT_COLOR)
            color_reg = value;
        else
            mask_reg = value;
    endtask

    task automatic set_colors(input logic [7:0] color, input logic [7:0] mask);
        wait_drained();
        write_reg(CFG_TEXT_COLOR, color);
        write_reg(CFG_GATE_MASK, mask);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_cursor_commands();
        tick(8'h00);                    // nothing running: empty result
        place_cursor(8'd0, 8'd0);
        place_cursor(8'd39, 8'd24);
        place_cursor(8'd40, 8'd0);
        place_cursor(8'd0, 8'd25);
        place_cursor(8'hFF, 8'hFF);
        start_at(8'd10, 8'd10);         // no terminator loaded yet
        start_at(8'd40, 8'd10);         // off screen is checked first
        wait_drained();
    endtask

    task automatic test_script_codes();
        script_q_t script;
        // glyphs, idle, space, column moves, newline, end
        script = {8'h41, BYTE_IDLE, BYTE_SPACE, 8'h21, 8'h7F, 8'h3F, 8'h01,
                  BYTE_NEWLINE, 8'hBF, 8'h80, 8'h40, BYTE_END};
        load_script(script);
        start_at(8'd5, 8'd3);
        tick(8'h01);                    // gated by the cadence mask
        play_script();
        tick(8'h00);                    // script over: empty result
        // load while running is refused and stops the script
        script = {8'h41, BYTE_END};
        load_script(script);
        start_at(8'd0, 8'd0);
        load_byte(8'h42);
        start_at(8'd0, 8'd0);           // terminator mark was cleared
        wait_drained();
    endtask

    task automatic test_edge_errors();
        script_q_t script;
        // newline on the last row
        script = {BYTE_NEWLINE, BYTE_END};
        load_script(script);
        start_at(8'd0, 8'd24);
        play_script();
        // column past the screen on the last row
        script = {8'hA8, 8'h41, BYTE_END};
        load_script(script);
        start_at(8'd0, 8'd24);
        play_script();
        // space autowrap in colour zero, then on the last row
        set_colors(8'h00, 8'h03);
        script = {BYTE_SPACE, BYTE_SPACE, BYTE_END};
        load_script(script);
        start_at(8'd30, 8'd5);
        play_script();
        script = {BYTE_SPACE, BYTE_END};
        load_script(script);
        start_at(8'd31, 8'd24);
        play_script();
        wait_drained();
    endtask

    // full store, fast bursts and the eight-bit column wrap, with no idling
    task automatic test_full_store_burst();
        steady_flow = 1'b1;
        set_colors(8'hFF, 8'h00);
        load_byte(8'hBF);
        repeat (SCRIPT_DEPTH - 2)
            load_byte(8'($urandom_range(8'h21, 8'h7F)));
        load_byte(BYTE_END);
        load_byte(8'h41);               // store full: refused
        start_at(8'd0, 8'd0);
        play_script();
        wait_drained();
        steady_flow = 1'b0;
    endtask

    function automatic logic [7:0] random_script_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 8'($urandom_range(8'h21, 8'h7F));
        else if (pick < 62)
            return BYTE_SPACE;
        else if (pick < 71)
            return BYTE_NEWLINE;
        else if (pick < 79)
            return BYTE_IDLE;
        else if (pick < 92)
            return 8'($urandom_range(8'h80, 8'hFE));
        else
            return 8'($urandom_range(8'h01, 8'hFE));
    endfunction

    task automatic random_session();
        script_q_t   script;
        int unsigned len;
        int unsigned pick;
        tsw_in_t     noise;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 14);
        repeat (len)
            script = {script, random_script_byte()};
        // now and then a script without its end byte
        if ($urandom_range(0, 99) >= 6)
            script = {script, BYTE_END};
        load_script(script);
        if ($urandom_range(0, 99) < 12)
            start_at(8'($urandom), 8'($urandom));
        else
            start_at(8'($urandom_range(0, SCREEN_COLUMNS - 1)),
                     8'($urandom_range(0, SCREEN_ROWS - 1)));
        while (script_running) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                noise = tsw_in_t'(IN_W'({$urandom, $urandom}));
                send_cmd(noise);
            end else if (pick < 80) begin
                tick(passing_frame());
            end else begin
                tick(8'($urandom));
            end
        end
        if ($urandom_range(0, 3) == 0)
            wait_drained();
    endtask

    task automatic test_random_scripts();
        int unsigned target;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_colors(8'h00, 8'h03);
                1: set_colors(8'hFF, 8'h00);
                2: set_colors(8'h00, 8'h00);
                3: set_colors(8'($urandom), 8'hFF);
                4: set_colors(8'($urandom_range(1, 254)), 8'h01);
                default: set_colors(8'h00, 8'($urandom_range(2, 15)));
            endcase
            target = items_sent + RANDOM_ITEMS / 6;
            while (items_sent < target)
                random_session();
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        reset_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_cursor_commands();
        test_script_codes();
        test_edge_errors();
        test_full_store_burst();
        test_random_scripts();

        wait_drained();
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && screen_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
